[hdl/mhic_pkg.sv]
`default_nettype none

package mhic_pkg;

  localparam int unsigned TIME_BITS     = 32;
  localparam int unsigned CONF_BITS     = 17;
  localparam int unsigned QUO_STEPS     = 17;
  localparam int unsigned STEP_CNT_BITS = 5;
  localparam int unsigned CFG_IDX_BITS  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_ELAPSED = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CONF_THRESH = 2'd2;

  // Configuration reset values
  localparam logic [TIME_BITS-1:0] RST_MIN_SAMPLES = 32'd1500;
  localparam logic [TIME_BITS-1:0] RST_MIN_ELAPSED = 32'd20000;
  localparam logic [CONF_BITS-1:0] RST_CONF_THRESH = 17'd58982;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_STOP   = 2'd2,
    ACT_QUERY  = 2'd3
  } mhic_action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_RANGE,
    ST_LOHI,
    ST_DIV,
    ST_DECIDE,
    ST_EMIT
  } mhic_state_e;

  typedef struct packed {
    logic capture;
    logic clear_run;
    logic take_sample;
    logic user_stop;
    logic load_ranges;
    logic load_lohi;
    logic div_step;
    logic decide;
    logic load_out;
  } mhic_cmd_t;

  typedef struct packed {
    mhic_action_e action;
    logic         run_live;
    logic         div_last;
  } mhic_stat_t;

endpackage

`default_nettype wire

[hdl/mag_hard_iron_minmax_calibrator.sv]
// Processing: a sample item during a live run passes through apply, range, min/max,
// 17 divide steps, decide and output load; other items go from apply to output load.
// Items are taken one at a time, the next only after the last result is loaded, which
// waits while the result stream stalls. The confidence divider makes one bit per cycle.
// Reset: asynchronous, active low; clears the run, the controller and the output valid,
// and loads the configuration registers with 1500, 20000 and 58982.
`default_nettype none

module mag_hard_iron_minmax_calibrator #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata, low bit up: mag_x, mag_y, mag_z, now_ms, zero pad
  input  wire logic [((3*SAMPLE_BITS+32+7)/8)*8-1:0] s_axis_tdata,
  // tuser: action
  input  wire logic [1:0]                          s_axis_tuser,
  // Result stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // tdata, low bit up: done_res, stopped_by_user, offset_x, offset_y, offset_z,
  // range_x, range_y, range_z, confidence, sample_count, elapsed_ms, zero pad
  output logic [((6*SAMPLE_BITS+86+7)/8)*8-1:0]    m_axis_tdata,
  // Configuration write channel
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [mhic_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [mhic_pkg::TIME_BITS-1:0]      cfg_data_i
);

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned TB     = mhic_pkg::TIME_BITS;
  localparam int unsigned OUT_W  = 6 * SAMPLE_BITS + 86;
  localparam int unsigned OUT_TW = ((6 * SAMPLE_BITS + 86 + 7) / 8) * 8;

  mhic_pkg::mhic_cmd_t  cmd;
  mhic_pkg::mhic_stat_t stat;

  logic                       done_res, stopped_by_user;
  logic signed [SB:0]         offset_x, offset_y, offset_z;
  logic [SB-1:0]              range_x, range_y, range_z;
  logic [mhic_pkg::CONF_BITS-1:0] confidence;
  logic [TB-1:0]              sample_count, elapsed_ms;

  // Configuration writes are taken in any cycle; the host writes only while idle.
  assign cfg_ready_o = 1'b1;

  mhic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mhic_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .action_i          (s_axis_tuser),
    .mag_x_i           (s_axis_tdata[SB-1:0]),
    .mag_y_i           (s_axis_tdata[2*SB-1:SB]),
    .mag_z_i           (s_axis_tdata[3*SB-1:2*SB]),
    .now_ms_i          (s_axis_tdata[3*SB+TB-1:3*SB]),
    .cfg_we_i          (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .done_res_o        (done_res),
    .stopped_by_user_o (stopped_by_user),
    .offset_x_o        (offset_x),
    .offset_y_o        (offset_y),
    .offset_z_o        (offset_z),
    .range_x_o         (range_x),
    .range_y_o         (range_y),
    .range_z_o         (range_z),
    .confidence_o      (confidence),
    .sample_count_o    (sample_count),
    .elapsed_ms_o      (elapsed_ms)
  );

  // Pack the result fields, first field in the low bits, zero pad to whole bytes.
  logic [OUT_W-1:0] out_packed;

  assign out_packed = {elapsed_ms, sample_count, confidence,
                       range_z, range_y, range_x,
                       offset_z, offset_y, offset_x,
                       stopped_by_user, done_res};

  assign m_axis_tdata = OUT_TW'(out_packed);

endmodule

`default_nettype wire

[hdl/mhic_ctrl.sv]
`default_nettype none

module mhic_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire mhic_pkg::mhic_stat_t stat_i,
  output mhic_pkg::mhic_cmd_t     cmd_o
);

  mhic_pkg::mhic_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mhic_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mhic_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = mhic_pkg::ST_APPLY;
      end
      mhic_pkg::ST_APPLY: begin
        if (stat_i.action == mhic_pkg::ACT_SAMPLE && stat_i.run_live) begin
          state_d = mhic_pkg::ST_RANGE;
        end else begin
          state_d = mhic_pkg::ST_EMIT;
        end
      end
      mhic_pkg::ST_RANGE:  state_d = mhic_pkg::ST_LOHI;
      mhic_pkg::ST_LOHI:   state_d = mhic_pkg::ST_DIV;
      mhic_pkg::ST_DIV: begin
        if (stat_i.div_last) state_d = mhic_pkg::ST_DECIDE;
      end
      mhic_pkg::ST_DECIDE: state_d = mhic_pkg::ST_EMIT;
      mhic_pkg::ST_EMIT: begin
        if (out_free) state_d = mhic_pkg::ST_IDLE;
      end
      default:             state_d = mhic_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mhic_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      mhic_pkg::ST_APPLY: begin
        case (stat_i.action)
          mhic_pkg::ACT_START:  cmd_o.clear_run   = 1'b1;
          mhic_pkg::ACT_SAMPLE: cmd_o.take_sample = stat_i.run_live;
          mhic_pkg::ACT_STOP:   cmd_o.user_stop   = stat_i.run_live;
          default:              cmd_o.clear_run   = 1'b0;
        endcase
      end
      mhic_pkg::ST_RANGE:  cmd_o.load_ranges = 1'b1;
      mhic_pkg::ST_LOHI:   cmd_o.load_lohi   = 1'b1;
      mhic_pkg::ST_DIV:    cmd_o.div_step    = 1'b1;
      mhic_pkg::ST_DECIDE: cmd_o.decide      = 1'b1;
      mhic_pkg::ST_EMIT:   cmd_o.load_out    = out_free;
      default:             cmd_o             = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[hdl/mhic_datapath.sv]
`default_nettype none

module mhic_datapath #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire mhic_pkg::mhic_cmd_t                   cmd_i,
  output mhic_pkg::mhic_stat_t                       stat_o,
  input  wire logic [1:0]                            action_i,
  input  wire logic signed [SAMPLE_BITS-1:0]         mag_x_i,
  input  wire logic signed [SAMPLE_BITS-1:0]         mag_y_i,
  input  wire logic signed [SAMPLE_BITS-1:0]         mag_z_i,
  input  wire logic [mhic_pkg::TIME_BITS-1:0]        now_ms_i,
  input  wire logic                                  cfg_we_i,
  input  wire logic [mhic_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  wire logic [mhic_pkg::TIME_BITS-1:0]        cfg_data_i,
  output logic                                       done_res_o,
  output logic                                       stopped_by_user_o,
  output logic signed [SAMPLE_BITS:0]                offset_x_o,
  output logic signed [SAMPLE_BITS:0]                offset_y_o,
  output logic signed [SAMPLE_BITS:0]                offset_z_o,
  output logic [SAMPLE_BITS-1:0]                     range_x_o,
  output logic [SAMPLE_BITS-1:0]                     range_y_o,
  output logic [SAMPLE_BITS-1:0]                     range_z_o,
  output logic [mhic_pkg::CONF_BITS-1:0]             confidence_o,
  output logic [mhic_pkg::TIME_BITS-1:0]             sample_count_o,
  output logic [mhic_pkg::TIME_BITS-1:0]             elapsed_ms_o
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned TB = mhic_pkg::TIME_BITS;
  localparam int unsigned CB = mhic_pkg::CONF_BITS;
  localparam int unsigned NB = mhic_pkg::STEP_CNT_BITS;

  localparam logic signed [SB-1:0] MOST_POS = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] MOST_NEG = {1'b1, {(SB-1){1'b0}}};
  localparam logic [NB-1:0]        LAST_STEP = NB'(mhic_pkg::QUO_STEPS - 1);

  // Configuration
  logic [TB-1:0] min_samples_q;
  logic [TB-1:0] min_elapsed_q;
  logic [CB-1:0] conf_thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_samples_q <= mhic_pkg::RST_MIN_SAMPLES;
      min_elapsed_q <= mhic_pkg::RST_MIN_ELAPSED;
      conf_thresh_q <= mhic_pkg::RST_CONF_THRESH;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mhic_pkg::CFG_MIN_SAMPLES: min_samples_q <= cfg_data_i;
        mhic_pkg::CFG_MIN_ELAPSED: min_elapsed_q <= cfg_data_i;
        mhic_pkg::CFG_CONF_THRESH: conf_thresh_q <= cfg_data_i[CB-1:0];
        default:                   min_samples_q <= min_samples_q;
      endcase
    end
  end

  // Captured item
  logic [1:0]            action_q;
  logic signed [SB-1:0]  mag_q [3];
  logic [TB-1:0]         now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      mag_q[0] <= mag_x_i;
      mag_q[1] <= mag_y_i;
      mag_q[2] <= mag_z_i;
      now_q    <= now_ms_i;
    end
  end

  // Run state
  logic                 active_q, done_q, stopped_q;
  logic [TB-1:0]        count_q, start_q;
  logic [CB-1:0]        conf_q;
  logic signed [SB-1:0] min_q [3];
  logic signed [SB-1:0] max_q [3];
  logic [TB-1:0]        elapsed;
  logic [CB-1:0]        conf_new;
  logic [SB-1:0]        hi_q;
  logic [CB-1:0]        quo_q;
  logic                 auto_done;

  assign elapsed   = now_q - start_q;
  assign conf_new  = (hi_q == '0) ? '0 : quo_q;
  assign auto_done = (count_q >= min_samples_q) && (elapsed >= min_elapsed_q) &&
                     (conf_new >= conf_thresh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      done_q    <= 1'b0;
      stopped_q <= 1'b0;
      count_q   <= '0;
      start_q   <= '0;
      conf_q    <= '0;
      for (int i = 0; i < 3; i++) begin
        min_q[i] <= MOST_POS;
        max_q[i] <= MOST_NEG;
      end
    end else begin
      if (cmd_i.clear_run) begin
        active_q  <= 1'b1;
        done_q    <= 1'b0;
        stopped_q <= 1'b0;
        count_q   <= '0;
        start_q   <= now_q;
        conf_q    <= '0;
        for (int i = 0; i < 3; i++) begin
          min_q[i] <= MOST_POS;
          max_q[i] <= MOST_NEG;
        end
      end
      if (cmd_i.take_sample) begin
        for (int i = 0; i < 3; i++) begin
          if (mag_q[i] < min_q[i]) min_q[i] <= mag_q[i];
          if (mag_q[i] > max_q[i]) max_q[i] <= mag_q[i];
        end
        if (count_q != '1) count_q <= count_q + 1'b1;
      end
      if (cmd_i.user_stop) begin
        stopped_q <= 1'b1;
        done_q    <= 1'b1;
      end
      if (cmd_i.decide) begin
        conf_q <= conf_new;
        if (auto_done) done_q <= 1'b1;
      end
    end
  end

  // Ranges, smallest and largest
  logic [SB-1:0] range_q [3];
  logic [SB-1:0] lo_d, hi_d, lo01, hi01;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_ranges) begin
      for (int i = 0; i < 3; i++) begin
        range_q[i] <= SB'(max_q[i] - min_q[i]);
      end
    end
  end

  always_comb begin
    lo01 = (range_q[0] < range_q[1]) ? range_q[0] : range_q[1];
    hi01 = (range_q[0] > range_q[1]) ? range_q[0] : range_q[1];
    lo_d = (range_q[2] < lo01) ? range_q[2] : lo01;
    hi_d = (range_q[2] > hi01) ? range_q[2] : hi01;
  end

  // Restoring division of lo * 2^16 by hi, one quotient bit per step.
  // lo <= hi, so the first step yields the integer bit.
  logic [SB:0]   rem_q;
  logic [NB-1:0] step_q;
  logic          rem_ge;
  logic [SB-1:0] rem_red;

  assign rem_ge  = rem_q >= {1'b0, hi_q};
  assign rem_red = rem_ge ? SB'(rem_q - {1'b0, hi_q}) : rem_q[SB-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_lohi) begin
      hi_q  <= hi_d;
      rem_q <= {1'b0, lo_d};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= {rem_red, 1'b0};
      quo_q <= {quo_q[CB-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.load_lohi) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + 1'b1;
    end
  end

  assign stat_o.action   = mhic_pkg::mhic_action_e'(action_q);
  assign stat_o.run_live = active_q && !done_q;
  assign stat_o.div_last = step_q == LAST_STEP;

  // Result register
  logic                 has_sample;
  logic signed [SB:0]   off_q [3];
  logic [SB-1:0]        rng_q [3];

  assign has_sample = count_q != '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      done_res_o        <= done_q;
      stopped_by_user_o <= stopped_q;
      for (int i = 0; i < 3; i++) begin
        off_q[i] <= has_sample ? ((SB + 1)'(max_q[i]) + (SB + 1)'(min_q[i])) : '0;
        rng_q[i] <= has_sample ? SB'(max_q[i] - min_q[i]) : '0;
      end
      confidence_o   <= has_sample ? conf_q : '0;
      sample_count_o <= count_q;
      elapsed_ms_o   <= elapsed;
    end
  end

  assign offset_x_o = off_q[0];
  assign offset_y_o = off_q[1];
  assign offset_z_o = off_q[2];
  assign range_x_o  = rng_q[0];
  assign range_y_o  = rng_q[1];
  assign range_z_o  = rng_q[2];

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import mhic_pkg::*;

  localparam int unsigned SBITS = 16;
  localparam int unsigned IN_W  = ((3*SBITS+32+7)/8)*8;
  localparam int unsigned OUT_W = ((6*SBITS+86+7)/8)*8;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

  // One calibration report, laid out as on m_axis_tdata (done in bit 0).
  typedef struct packed {
    logic [31:0]      elapsed;
    logic [31:0]      count;
    logic [16:0]      conf;
    logic [2:0][15:0] span;
    logic [2:0][16:0] offset;
    logic             stopped;
    logic             done;
  } cal_report_t;

  localparam int unsigned REPORT_W = $bits(cal_report_t);

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic [1:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [TIME_BITS-1:0]    cfg_data_i;

  mag_hard_iron_minmax_calibrator #(.SAMPLE_BITS(SBITS)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Calibrator state as the testbench tracks it
  logic signed [15:0] ext_min [3];
  logic signed [15:0] ext_max [3];
  logic [31:0]        n_samples;
  logic [31:0]        t_start;
  logic               run_on;
  logic               run_fin;
  logic               by_user;
  logic [16:0]        cur_conf;
  // Completion thresholds
  logic [31:0]        need_samples;
  logic [31:0]        need_ms;
  logic [16:0]        need_conf;

  cal_report_t pending_reports[$];
  int          mismatches = 0;
  int          burst_left = 0;
  bit          sender_eager = 1'b0;
  bit          hold_tgl = 1'b0;

  function automatic void clear_extremes();
    for (int i = 0; i < 3; i++) begin
      ext_min[i] = 16'sh7FFF;
      ext_max[i] = 16'sh8000;
    end
  endfunction

  // Apply one action to the tracked state and build the report it yields.
  function automatic cal_report_t predict_report(input mhic_action_e act,
                                                 input logic [15:0] sx, sy, sz,
                                                 input logic [31:0] now);
    cal_report_t        r;
    logic signed [15:0] s [3];
    int                 d, lo, hi, i;
    s[0] = sx;
    s[1] = sy;
    s[2] = sz;
    case (act)
      ACT_START: begin
        run_on    = 1'b1;
        run_fin   = 1'b0;
        by_user   = 1'b0;
        t_start   = now;
        n_samples = '0;
        cur_conf  = '0;
        clear_extremes();
      end
      ACT_SAMPLE: begin
        if (run_on && !run_fin) begin
          lo = 65536;
          hi = 0;
          for (i = 0; i < 3; i++) begin
            if (s[i] < ext_min[i]) ext_min[i] = s[i];
            if (s[i] > ext_max[i]) ext_max[i] = s[i];
            d = int'(ext_max[i]) - int'(ext_min[i]);
            if (d < lo) lo = d;
            if (d > hi) hi = d;
          end
          if (n_samples != 32'hFFFF_FFFF) n_samples++;
          cur_conf = (hi == 0) ? 17'd0 : 17'((longint'(lo) << 16) / hi);
          if (n_samples >= need_samples && (now - t_start) >= need_ms &&
              cur_conf >= need_conf)
            run_fin = 1'b1;
        end
      end
      ACT_STOP: begin
        if (run_on && !run_fin) begin
          by_user = 1'b1;
          run_fin = 1'b1;
        end
      end
      default: ;
    endcase
    r.done    = run_fin;
    r.stopped = by_user;
    for (i = 0; i < 3; i++) begin
      if (n_samples != 0) begin
        r.offset[i] = 17'(int'(ext_max[i]) + int'(ext_min[i]));
        r.span[i]   = 16'(int'(ext_max[i]) - int'(ext_min[i]));
      end else begin
        r.offset[i] = '0;
        r.span[i]   = '0;
      end
    end
    r.conf    = (n_samples != 0) ? cur_conf : 17'd0;
    r.count   = n_samples;
    r.elapsed = now - t_start;
    return r;
  endfunction

  // Offer one item; tvalid stays high into the next call unless a gap follows.
  task automatic send_item(input mhic_action_e act, input logic [15:0] sx, sy, sz,
                           input logic [31:0] now);
    int gap;
    gap = 0;
    if (burst_left == 0 && !sender_eager) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    end
    if (burst_left > 0) burst_left--;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {now, sz, sy, sx};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_reports.push_back(predict_report(act, sx, sy, sz, now));
  endtask

  // Drop the stream and wait for every outstanding report.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MIN_SAMPLES: need_samples = val;
      CFG_MIN_ELAPSED: need_ms      = val;
      CFG_CONF_THRESH: need_conf    = val[16:0];
      default: ;
    endcase
  endtask

  // Reprogram all thresholds while the block is idle; the unused index is poked too.
  task automatic set_thresholds(input logic [31:0] n, input logic [31:0] ms,
                                input logic [31:0] thr);
    settle();
    cfg_write(CFG_UNUSED, $urandom);
    cfg_write(CFG_MIN_SAMPLES, n);
    cfg_write(CFG_MIN_ELAPSED, ms);
    cfg_write(CFG_CONF_THRESH, thr);
    cfg_valid_i <= 1'b0;
  endtask

  // Sample around center c with half-width a, often right on the edge.
  function automatic logic [15:0] near(input int c, input int a);
    int v;
    if ($urandom_range(0, 2) == 0) v = $urandom_range(0, 1) ? c + a : c - a;
    else v = c - a + int'($urandom_range(0, 2 * a));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic test_idle_actions();
    send_item(ACT_QUERY, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
    send_item(ACT_SAMPLE, 16'h7FFF, 16'h8000, 16'h1234, 32'hFFFF_FFFF);
    send_item(ACT_STOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h8000_0000);
    send_item(ACT_QUERY, 16'hFFFF, 16'h0000, 16'hFFFF, 32'h0000_1234);
  endtask

  task automatic test_run_basics();
    // start near the top of the timestamp so elapsed wraps
    send_item(ACT_START, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFF0);
    send_item(ACT_QUERY, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFF8);
    send_item(ACT_SAMPLE, 16'h7FFF, 16'h8000, 16'h0000, 32'hFFFF_FFFC);
    send_item(ACT_SAMPLE, 16'h8000, 16'h7FFF, 16'hFFFF, 32'h0000_0004);
    send_item(ACT_QUERY, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0020);
    // restart mid-run, then one flat sample gives zero ranges
    send_item(ACT_START, 16'h0000, 16'h0000, 16'h0000, 32'd100);
    send_item(ACT_SAMPLE, 16'h0005, 16'h0005, 16'h0005, 32'd150);
    send_item(ACT_STOP, 16'h0000, 16'h0000, 16'h0000, 32'd200);
    send_item(ACT_SAMPLE, 16'h7FFF, 16'h8000, 16'h7FFF, 32'd210);
    send_item(ACT_STOP, 16'h0000, 16'h0000, 16'h0000, 32'd220);
    send_item(ACT_QUERY, 16'h0000, 16'h0000, 16'h0000, 32'd230);
  endtask

  task automatic test_auto_complete();
    // zero thresholds: the first sample finishes the run
    set_thresholds(32'd0, 32'd0, 32'd0);
    send_item(ACT_START, 16'h0000, 16'h0000, 16'h0000, 32'd10);
    send_item(ACT_SAMPLE, 16'h0042, 16'hFF00, 16'h0001, 32'd10);
    // full confidence needs equal ranges on all axes
    set_thresholds(32'd2, 32'd0, 32'd65536);
    send_item(ACT_START, 16'h0000, 16'h0000, 16'h0000, 32'd0);
    send_item(ACT_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 32'd1);
    send_item(ACT_SAMPLE, 16'd100, 16'd100, 16'd100, 32'd2);
    send_item(ACT_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd3);
    // elapsed time gates completion
    set_thresholds(32'd1, 32'd1000, 32'd0);
    send_item(ACT_START, 16'h0000, 16'h0000, 16'h0000, 32'd5000);
    send_item(ACT_SAMPLE, 16'd3, 16'd3, 16'd3, 32'd5999);
    send_item(ACT_SAMPLE, 16'd4, 16'd4, 16'd4, 32'd6000);
    // threshold beyond 1.0 and maximal counts: the run never ends by itself
    set_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_START, 16'h0000, 16'h0000, 16'h0000, 32'd0);
    send_item(ACT_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF);
    send_item(ACT_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 32'hFFFF_FFFE);
    send_item(ACT_QUERY, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
  endtask

  // Hold the result side for a long stretch while items keep coming.
  task automatic test_backpressure();
    int k;
    set_thresholds(32'd1500, 32'd20000, 32'd58982);
    sender_eager = 1'b1;
    hold_tgl <= ~hold_tgl;
    send_item(ACT_START, 16'($urandom), 16'($urandom), 16'($urandom), 32'd0);
    for (k = 0; k < 12; k++) begin
      if (k % 3 == 0)
        send_item(ACT_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom), 32'(k));
      else
        send_item(ACT_QUERY, 16'($urandom), 16'($urandom), 16'($urandom), 32'(k));
    end
    sender_eager = 1'b0;
  endtask

  task automatic test_random_runs();
    int          ph, sent, run_len, k, ax, a_base;
    bit          equal;
    int          ctr [3];
    int          amp [3];
    logic [31:0] now;
    logic [15:0] v [3];
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: set_thresholds($urandom_range(1, 40), $urandom_range(0, 2000),
                          {15'($urandom), 17'($urandom_range(30000, 65536))});
        1: set_thresholds($urandom_range(0, 8), 32'd0, {15'($urandom), 17'd0});
        2: set_thresholds($urandom_range(5, 30), $urandom_range(0, 3000), 32'd65536);
        default: set_thresholds($urandom, $urandom, $urandom);
      endcase
      sent = 0;
      while (sent < 105) begin
        if ($urandom_range(0, 6) == 0) begin
          // noise: any action with any content
          send_item(mhic_action_e'(2'($urandom_range(0, 3))), 16'($urandom),
                    16'($urandom), 16'($urandom), $urandom);
          sent++;
        end else begin
          now = $urandom;
          send_item(ACT_START, 16'($urandom), 16'($urandom), 16'($urandom), now);
          sent++;
          a_base = $urandom_range(0, 16000);
          equal  = ($urandom_range(0, 2) == 0);
          for (ax = 0; ax < 3; ax++) begin
            ctr[ax] = int'($urandom_range(0, 20000)) - 10000;
            amp[ax] = equal ? a_base : a_base * int'($urandom_range(80, 120)) / 100;
          end
          run_len = $urandom_range(3, 40);
          for (k = 0; k < run_len; k++) begin
            now += $urandom_range(0, 300);
            if ($urandom_range(0, 19) == 0) begin
              send_item(ACT_QUERY, 16'($urandom), 16'($urandom), 16'($urandom), now);
            end else if (k > 0 && $urandom_range(0, 24) == 0) begin
              send_item(ACT_STOP, 16'($urandom), 16'($urandom), 16'($urandom), now);
            end else begin
              for (ax = 0; ax < 3; ax++) v[ax] = near(ctr[ax], amp[ax]);
              send_item(ACT_SAMPLE, v[0], v[1], v[2], now);
            end
            sent++;
            // after the run ends, poke it once more at most and move on
            if (run_fin) begin
              if ($urandom_range(0, 2) == 0)
                send_item(ACT_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom), now);
              break;
            end
          end
        end
      end
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare every accepted report with the oldest prediction.
  always @(posedge clk_i) begin : report_check
    cal_report_t want;
    cal_report_t got;
    string       axis;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = cal_report_t'(m_axis_tdata[REPORT_W-1:0]);
      if (pending_reports.size() == 0) begin
        $error("report with no item outstanding: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("done_res", longint'(want.done), longint'(got.done));
        check_field("stopped_by_user", longint'(want.stopped), longint'(got.stopped));
        for (int i = 0; i < 3; i++) begin
          axis = (i == 0) ? "x" : (i == 1) ? "y" : "z";
          check_field({"offset_", axis}, longint'($signed(want.offset[i])),
                      longint'($signed(got.offset[i])));
          check_field({"range_", axis}, longint'(want.span[i]), longint'(got.span[i]));
        end
        check_field("confidence", longint'(want.conf), longint'(got.conf));
        check_field("sample_count", longint'(want.count), longint'(got.count));
        check_field("elapsed_ms", longint'(want.elapsed), longint'(got.elapsed));
        check_field("tdata_pad", 64'sd0, longint'(m_axis_tdata[OUT_W-1:REPORT_W]));
      end
    end
  end

  // Result side: a changing stall pattern, plus one long hold on request.
  initial begin : result_sink
    int hold_left;
    int mode;
    int cyc;
    bit seen;
    hold_left = 0;
    mode = 0;
    cyc = 0;
    seen = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (seen != hold_tgl) begin
        seen = hold_tgl;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (cyc % 50 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= ((cyc / 3) % 2 == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    need_samples  = RST_MIN_SAMPLES;
    need_ms       = RST_MIN_ELAPSED;
    need_conf     = RST_CONF_THRESH;
    n_samples     = '0;
    t_start       = '0;
    run_on        = 1'b0;
    run_fin       = 1'b0;
    by_user       = 1'b0;
    cur_conf      = '0;
    clear_extremes();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_actions();
    test_run_basics();
    test_auto_complete();
    test_backpressure();
    test_random_runs();

    settle();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
hdl/mhic_pkg.sv
hdl/mhic_ctrl.sv
hdl/mhic_datapath.sv
hdl/mag_hard_iron_minmax_calibrator.sv
verif/tb.sv
